@@ hdl/utf8_to_codepoint_decoder_top_assert.svh @@
// assertion macros shared by the checker
`ifndef UTF8_TO_CODEPOINT_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UTDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utdec assertion failed");

// next-cycle implication, disabled while in reset
`define UTDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utdec assertion failed");

`endif

@@ hdl/utdec_pkg.sv @@
// types and constants of the utf-8 decoder
package utdec_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned HELD_MAX  = 3;

  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  typedef logic [CP_W-1:0] cp_t;

  // decoder state held between beats
  typedef struct packed {
    logic [7:0]      held_lead;
    logic [1:0][7:0] held_tail;
    logic [1:0]      held_count;
    logic [2:0]      seq_length;
  } dec_state_t;

  // results of one input beat
  typedef struct packed {
    logic [2:0]            n;
    logic [MAX_RES-1:0][CP_W-1:0] cp;
  } burst_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b >= LEAD4_MIN)      len = LEN_4;
    else if (b >= LEAD3_MIN) len = LEN_3;
    else if (b >= LEAD2_MIN) len = LEN_2;
    else                     len = LEN_1;
    return len;
  endfunction

  function automatic cp_t raw_cp(input logic [7:0] b);
    return {{(CP_W-8){1'b0}}, b};
  endfunction

endpackage

@@ hdl/utdec_step.sv @@
// combinational decode of one byte against the held sequence
module utdec_step
  import utdec_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output dec_state_t nxt,
  output burst_t     res
);

  logic       cont;
  logic [2:0] len;
  logic [2:0] count_inc;
  logic       tail_idx;
  cp_t        assembled;
  dec_state_t fs;
  logic       do_flush;

  assign cont      = (data_byte & CONT_MASK) == CONT_TAG;
  assign len       = lead_length(data_byte);
  assign count_inc = {1'b0, cur.held_count} + 3'd1;
  assign tail_idx  = 1'(cur.held_count - 2'd1);

  always_comb begin
    case (cur.seq_length)
      LEN_4:   assembled = {cur.held_lead[2:0], cur.held_tail[0][5:0],
                            cur.held_tail[1][5:0], data_byte[5:0]};
      LEN_3:   assembled = {5'd0, cur.held_lead[3:0], cur.held_tail[0][5:0],
                            data_byte[5:0]};
      default: assembled = {10'd0, cur.held_lead[4:0], data_byte[5:0]};
    endcase
  end

  always_comb begin
    nxt      = cur;
    res      = '0;
    fs       = cur;
    do_flush = 1'b0;
    if (cur.held_count != 2'd0 && cont) begin
      if (count_inc >= cur.seq_length) begin
        res.cp[0]      = assembled;
        res.n          = 3'd1;
        nxt.held_lead  = 8'd0;
        nxt.held_count = 2'd0;
        nxt.seq_length = 3'd0;
      end else begin
        nxt.held_tail[tail_idx] = data_byte;
        nxt.held_count          = count_inc[1:0];
        if (final_byte) begin
          // truncated at end of text: held bytes plus this one go out raw
          fs       = nxt;
          do_flush = 1'b1;
        end
      end
    end else if (cur.held_count != 2'd0) begin
      do_flush = 1'b1;
    end

    if (do_flush) begin
      res.cp[0] = raw_cp(fs.held_lead);
      res.n     = 3'd1;
      if (fs.held_count >= 2'd2) begin
        res.cp[1] = raw_cp(fs.held_tail[0]);
        res.n     = 3'd2;
      end
      if (fs.held_count == 2'd3) begin
        res.cp[2] = raw_cp(fs.held_tail[1]);
        res.n     = 3'd3;
      end
      nxt.held_lead  = 8'd0;
      nxt.held_count = 2'd0;
      nxt.seq_length = 3'd0;
    end

    if (!(cur.held_count != 2'd0 && cont)) begin
      if (!final_byte && len > LEN_1) begin
        nxt.held_lead  = data_byte;
        nxt.held_count = 2'd1;
        nxt.seq_length = len;
      end else begin
        res.cp[res.n[1:0]] = raw_cp(data_byte);
        res.n              = res.n + 3'd1;
      end
    end
  end

endmodule

@@ hdl/utdec_burst.sv @@
// result register: holds the code points of one beat and drains them in order
module utdec_burst
  import utdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  burst_t       res,
  input  logic         load_fin,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [20:0]  code_point,
  output logic         run_last,
  output logic         text_end
);

  logic [MAX_RES-1:0][CP_W-1:0] slots;
  logic [2:0]                   rem;
  logic                         fin;

  assign out_valid  = rem != 3'd0;
  assign code_point = slots[0];
  assign run_last   = rem == 3'd1;
  assign text_end   = run_last && fin;
  assign free       = (rem == 3'd0) || (rem == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= res.n;
    end else if (out_valid && out_ready) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= res.cp;
      fin   <= load_fin;
    end else if (out_valid && out_ready) begin
      slots <= {{CP_W{1'b0}}, slots[MAX_RES-1:1]};
    end
  end

endmodule

@@ hdl/utf8_to_codepoint_decoder_top.sv @@
// top level of the utf-8 to code point decoder
//
//  channel | signals                                  | beat
//  --------+------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, data_byte, final_byte | one text byte
//  out     | out_valid, out_ready, code_point,         | one code point, 0 to 4 per
//          | run_last, text_end                        | input byte
//
// one input byte a cycle while each byte yields at most one code point and out does not stall
// a byte that yields k code points holds the result register until all k are drained
// (k up to 4, for a broken or truncated sequence)
// each byte passes through the input register, then the result register
// synchronous reset empties both registers and drops any held sequence
// a stall on out fills the result register, then the input register, then drops in_ready
module utf8_to_codepoint_decoder_top
  import utdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic        run_last,
  output logic        text_end
);

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_fin;

  // held sequence
  logic [7:0]      held_lead;
  logic [1:0][7:0] held_tail;
  logic [1:0]      held_count;
  logic [2:0]      seq_length;

  dec_state_t cur;
  dec_state_t state_next;
  burst_t     res;
  logic       burst_free;
  logic       advance;

  // the staged byte moves on once the result register can take its burst
  assign advance  = stage_valid && burst_free;
  assign in_ready = !stage_valid || advance;

  assign cur.held_lead  = held_lead;
  assign cur.held_tail  = held_tail;
  assign cur.held_count = held_count;
  assign cur.seq_length = seq_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= data_byte;
      stage_fin  <= final_byte;
    end
  end

  // control part of the held sequence is cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead  <= 8'd0;
      held_count <= 2'd0;
      seq_length <= 3'd0;
    end else if (advance) begin
      held_lead  <= state_next.held_lead;
      held_count <= state_next.held_count;
      seq_length <= state_next.seq_length;
    end
  end

  // tail bytes are only read after they are written
  always_ff @(posedge clk) begin
    if (advance) begin
      held_tail <= state_next.held_tail;
    end
  end

  utdec_step u_step (
    .cur        (cur),
    .data_byte  (stage_byte),
    .final_byte (stage_fin),
    .nxt        (state_next),
    .res        (res)
  );

  utdec_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .res        (res),
    .load_fin   (stage_fin),
    .free       (burst_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .run_last   (run_last),
    .text_end   (text_end)
  );

endmodule

@@ hdl/utdec_checker.sv @@
// port-level checks of the decoder and their bind
`include "utf8_to_codepoint_decoder_top_assert.svh"

module utdec_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic        run_last,
  input logic        text_end
);

  // end of text only on the last code point of a burst
  `UTDEC_ASSERT_NOW(a_end_on_last, clk, rst, out_valid && text_end, run_last)

  // a burst drains without a gap
  `UTDEC_ASSERT_NEXT(a_burst_cont, clk, rst, out_valid && out_ready && !run_last, out_valid)

  // a stalled result stays offered
  `UTDEC_ASSERT_NEXT(a_stall_valid, clk, rst, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `UTDEC_ASSERT_NEXT(a_stall_data, clk, rst, out_valid && !out_ready,
    $stable(code_point) && $stable(run_last) && $stable(text_end))

endmodule

bind utf8_to_codepoint_decoder_top utdec_checker u_utdec_checker (.*);

@@ tb/utf8_to_codepoint_decoder_top_test.sv @@
// self-checking testbench of the utf-8 to code point decoder top level
module utf8_to_codepoint_decoder_top_test
  import utdec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // payload masks of the lead byte, by sequence length, and of a continuation
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

  localparam int unsigned RANDOM_BEATS = 330;
  localparam int unsigned DIR_ROWS     = 25;

  // one expected code point beat
  typedef struct packed {
    cp_t  cp;
    logic run_last;
    logic text_end;
  } cp_beat_t;

  // one directed stimulus row; typed rows carry their single expected code point
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    cp_t        cp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] code_point;
  logic        run_last;
  logic        text_end;

  utf8_to_codepoint_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .final_byte(final_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_point(code_point),
    .run_last  (run_last),
    .text_end  (text_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // decoder state as predicted from the accepted input beats
  // ---------------------------------------------------------------------------
  logic [7:0] hold_lead = 8'h00;
  logic [7:0] hold_tail [0:1];
  int         hold_cnt = 0;
  int         hold_len = 0;

  // code points produced by the latest input beat, and those still awaited
  cp_t        step_cp [0:MAX_RES-1];
  cp_beat_t   pending_cps [$];
  int         err_count = 0;

  // emit every held byte raw, lead first, then forget the sequence
  function automatic int spill_held(input int n);
    int k;
    k = n;
    if (hold_cnt > 0) begin
      step_cp[k] = cp_t'(hold_lead);
      k++;
      for (int i = 1; i < hold_cnt && i <= 2; i++) begin
        step_cp[k] = cp_t'(hold_tail[i-1]);
        k++;
      end
    end
    hold_lead = 8'h00;
    hold_cnt  = 0;
    hold_len  = 0;
    return k;
  endfunction

  // advance the predicted state by one byte; returns how many code points it yields
  function automatic int decode_byte(input logic [7:0] b, input logic fin);
    int         n;
    logic       cont;
    logic [2:0] len;
    cp_t        cp;
    n    = 0;
    cont = ((b & CONT_MASK) == CONT_TAG);
    if (hold_cnt > 0 && cont) begin
      if (hold_cnt + 1 >= hold_len) begin
        // sequence complete: lead payload, then six bits per continuation
        case (hold_len)
          LEN_4:   cp = cp_t'(hold_lead & LEAD4_BITS);
          LEN_3:   cp = cp_t'(hold_lead & LEAD3_BITS);
          default: cp = cp_t'(hold_lead & LEAD2_BITS);
        endcase
        for (int i = 1; i + 1 < hold_len && i <= 2; i++)
          cp = (cp << 6) | cp_t'(hold_tail[i-1] & CONT_BITS);
        cp = (cp << 6) | cp_t'(b & CONT_BITS);
        step_cp[n] = cp;
        n++;
        hold_lead = 8'h00;
        hold_cnt  = 0;
        hold_len  = 0;
      end else begin
        hold_tail[(hold_cnt - 1) & 1] = b;
        hold_cnt++;
        // truncated at the end of the text: all of it goes out raw
        if (fin) n = spill_held(n);
      end
    end else begin
      // a broken sequence goes out raw before the new byte is looked at
      if (hold_cnt > 0) n = spill_held(n);
      if (b >= LEAD4_MIN)      len = LEN_4;
      else if (b >= LEAD3_MIN) len = LEN_3;
      else if (b >= LEAD2_MIN) len = LEN_2;
      else                     len = LEN_1;
      if (!fin && len > LEN_1) begin
        hold_lead = b;
        hold_cnt  = 1;
        hold_len  = len;
      end else begin
        // ascii, stray continuation, or a lead that the text end cuts off
        step_cp[n] = cp_t'(b);
        n++;
      end
    end
    return n;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    case (len)
      2:       return 8'($urandom_range(LEAD2_MIN, LEAD3_MIN - 1));
      3:       return 8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
      default: return 8'($urandom_range(LEAD4_MIN, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return CONT_TAG | 8'($urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one beat per call, optional idle gap ahead of it
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic fin, input logic typed,
                           input cp_t tcp, input bit calm);
    int       gap;
    int       n;
    cp_beat_t beat;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: queue what it should yield
    n = decode_byte(b, fin);
    if (typed) begin
      beat = '{cp: tcp, run_last: 1'b1, text_end: fin};
      pending_cps.insert(pending_cps.size(), beat);
    end else begin
      for (int k = 0; k < n; k++) begin
        beat = '{cp: step_cp[k], run_last: (k == n - 1),
                 text_end: (k == n - 1) && fin};
        pending_cps.insert(pending_cps.size(), beat);
      end
    end
  endtask

  // directed rows: extremes, each sequence length, and the error paths
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000},  // lowest byte right after reset
    '{8'h7F, 1'b0, 1'b1, 21'h00007F},  // highest ascii
    '{8'h80, 1'b0, 1'b1, 21'h000080},  // stray continuation, low end
    '{8'hBF, 1'b0, 1'b1, 21'h0000BF},  // stray continuation, high end
    '{8'hC2, 1'b0, 1'b0, 21'h0},       // two-byte sequence
    '{8'hA9, 1'b0, 1'b0, 21'h0},
    '{8'hE2, 1'b0, 1'b0, 21'h0},       // three-byte sequence
    '{8'h82, 1'b0, 1'b0, 21'h0},
    '{8'hAC, 1'b0, 1'b0, 21'h0},
    '{8'hF0, 1'b0, 1'b0, 21'h0},       // four-byte sequence
    '{8'h9F, 1'b0, 1'b0, 21'h0},
    '{8'h98, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'hFF, 1'b0, 1'b0, 21'h0},       // 0xff lead, all payload bits set
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b1, 21'h1FFFFF},  // largest code point
    '{8'hF0, 1'b0, 1'b0, 21'h0},       // broken four-byte sequence
    '{8'h90, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'h41, 1'b0, 1'b0, 21'h0},       // four raw code points out of one beat
    '{8'hC3, 1'b1, 1'b1, 21'h0000C3},  // lead as the last byte of the text
    '{8'hF4, 1'b0, 1'b0, 21'h0},       // truncated at the end of the text
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b1, 1'b0, 21'h0}
  };

  // ---------------------------------------------------------------------------
  // output side: ready with random stalls; the stall rate is redrawn each time the 6-bit phase counter wraps
  // ---------------------------------------------------------------------------
  int       ready_hold = 0;
  int       stall_pct = 0;
  bit [5:0] phase_cnt = '0;

  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1'b1;
    if (phase_cnt == 6'd63) begin
      case ($urandom_range(0, 2))
        0:       stall_pct <= 0;
        1:       stall_pct <= 10;
        default: stall_pct <= 35;
      endcase
    end
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) ready_hold <= pick_gap(1'b0);
    end
  end

  // every output beat is checked against the oldest awaited code point
  always @(posedge clk) begin
    cp_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cps.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual cp %h run_last %b text_end %b",
                 $time, code_point, run_last, text_end);
        err_count++;
      end else begin
        want = pending_cps.pop_front();
        if (code_point !== want.cp) begin
          $display("%0t code_point mismatch: expected %h actual %h",
                   $time, want.cp, code_point);
          err_count++;
        end
        if (run_last !== want.run_last) begin
          $display("%0t run_last mismatch: expected %b actual %b",
                   $time, want.run_last, run_last);
          err_count++;
        end
        if (text_end !== want.text_end) begin
          $display("%0t text_end mismatch: expected %b actual %b",
                   $time, want.text_end, text_end);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] text_q [$];
    int         sent;
    int         r;
    int         len;
    bit         calm;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].cp, 1'b0);

    // random texts: mostly well-formed characters, some noise and broken runs
    while (sent < RANDOM_BEATS) begin
      text_q.delete();
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
        end else if (r < 75) begin
          len = $urandom_range(2, 4);
          text_q.insert(text_q.size(), rand_lead(len));
          repeat (len - 1) text_q.insert(text_q.size(), rand_cont());
        end else if (r < 83) begin
          text_q.insert(text_q.size(), rand_cont());
        end else if (r < 93) begin
          // sequence cut short by a byte that is not a continuation
          len = $urandom_range(2, 4);
          text_q.insert(text_q.size(), rand_lead(len));
          repeat ($urandom_range(0, len - 2)) text_q.insert(text_q.size(), rand_cont());
          if ($urandom_range(0, 1) == 0)
            text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
          else
            text_q.insert(text_q.size(), rand_lead($urandom_range(2, 4)));
        end else begin
          text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end
      end
      // now and then the text stops inside a sequence
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(2, 4);
        text_q.insert(text_q.size(), rand_lead(len));
        repeat ($urandom_range(0, len - 2)) text_q.insert(text_q.size(), rand_cont());
      end
      calm = ($urandom_range(0, 3) == 0);
      foreach (text_q[i])
        send_beat(text_q[i], (i == text_q.size() - 1), 1'b0, '0, calm);
      sent += text_q.size();
    end

    in_valid <= 1'b0;
    while (pending_cps.size() > 0) @(posedge clk);
    // watch a while longer for beats that should not come
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("utf8_to_codepoint_decoder_top verification clean");
    end else begin
      $display("utf8_to_codepoint_decoder_top verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("utf8_to_codepoint_decoder_top verification failed");
    $finish;
  end

endmodule
